// ===== design/ftbc_pkg.sv =====
package ftbc_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [31:0] IDX_MASK = 32'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] TOP_MAX = 3'd7;
  localparam logic [2:0] TOP_RST = 3'd3;
  localparam logic [1:0] PAIR_MAX = 2'd3;
  localparam logic [1:0] LOW_RST_EVEN = 2'd2;
  localparam logic [1:0] LOW_RST_ODD = 2'd1;
  localparam logic [1:0] HIGH_RST_EVEN = 2'd1;
  localparam logic [1:0] HIGH_RST_ODD = 2'd2;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic upd_wr;
    logic res_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_upd;
    logic out_full;
  } sts_t;

endpackage

// ===== design/ftbc_ctrl.sv =====
module ftbc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ftbc_pkg::sts_t sts,
  output ftbc_pkg::cmd_t cmd
);
  import ftbc_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.op_upd) begin
          cmd.upd_wr = 1'b1;
          state_nxt = ST_IDLE;
        end else if (!sts.out_full) begin
          cmd.res_ld = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// ===== design/ftbc_dp.sv =====
module ftbc_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  ftbc_pkg::cmd_t cmd,
  output ftbc_pkg::sts_t sts,
  input  logic           in_op,
  input  logic [31:0]    in_branch_address,
  input  logic [3:0]     in_component_guesses,
  input  logic           in_taken_outcome,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_chosen_component,
  output logic           out_final_guess
);
  import ftbc_pkg::*;

  logic [2:0] top_mem [TABLE_ENTRIES];
  logic [1:0] low_mem [TABLE_ENTRIES];
  logic [1:0] high_mem [TABLE_ENTRIES];

  logic             op_r;
  logic [IDX_W-1:0] idx_r;
  logic [3:0]       guess_r;
  logic             outcome_r;
  logic [IDX_W-1:0] clr_r;
  logic [2:0]       top_rd_r;
  logic [1:0]       low_rd_r;
  logic [1:0]       high_rd_r;
  logic             out_valid_r;
  logic [1:0]       chosen_r;
  logic             final_r;

  logic [1:0]       chosen;
  logic [1:0]       high_pick;
  logic             low_guess;
  logic             high_guess;
  logic [2:0]       top_new;
  logic [1:0]       low_new;
  logic [1:0]       high_new;
  logic             we;
  logic [IDX_W-1:0] wr_idx;
  logic [2:0]       top_wd;
  logic [1:0]       low_wd;
  logic [1:0]       high_wd;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      idx_r     <= in_branch_address[IDX_W-1:0] & IDX_MASK[IDX_W-1:0];
      guess_r   <= in_component_guesses;
      outcome_r <= in_taken_outcome;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    top_rd_r  <= top_mem[idx_r];
    low_rd_r  <= low_mem[idx_r];
    high_rd_r <= high_mem[idx_r];
  end

  assign high_pick  = {1'b1, high_rd_r[1]};
  assign low_guess  = guess_r[{1'b0, low_rd_r[1]}];
  assign high_guess = guess_r[high_pick];
  assign chosen     = top_rd_r[2] ? high_pick : {1'b0, low_rd_r[1]};

  always_comb begin
    top_new = top_rd_r;
    if (low_guess != high_guess) begin
      if (high_guess == outcome_r) begin
        if (top_rd_r != TOP_MAX) begin
          top_new = top_rd_r + 3'd1;
        end
      end else if (top_rd_r != 3'd0) begin
        top_new = top_rd_r - 3'd1;
      end
    end
    low_new = low_rd_r;
    if (guess_r[0] != guess_r[1]) begin
      if (guess_r[1] == outcome_r) begin
        if (low_rd_r != PAIR_MAX) begin
          low_new = low_rd_r + 2'd1;
        end
      end else if (low_rd_r != 2'd0) begin
        low_new = low_rd_r - 2'd1;
      end
    end
    high_new = high_rd_r;
    if (guess_r[2] != guess_r[3]) begin
      if (guess_r[3] == outcome_r) begin
        if (high_rd_r != PAIR_MAX) begin
          high_new = high_rd_r + 2'd1;
        end
      end else if (high_rd_r != 2'd0) begin
        high_new = high_rd_r - 2'd1;
      end
    end
  end

  always_comb begin
    we = cmd.clr_wr | cmd.upd_wr;
    if (cmd.clr_wr) begin
      wr_idx  = clr_r;
      top_wd  = TOP_RST;
      low_wd  = clr_r[0] ? LOW_RST_ODD : LOW_RST_EVEN;
      high_wd = clr_r[0] ? HIGH_RST_ODD : HIGH_RST_EVEN;
    end else begin
      wr_idx  = idx_r;
      top_wd  = top_new;
      low_wd  = low_new;
      high_wd = high_new;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      top_mem[wr_idx]  <= top_wd;
      low_mem[wr_idx]  <= low_wd;
      high_mem[wr_idx] <= high_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      chosen_r <= chosen;
      final_r  <= guess_r[chosen];
    end
  end

  assign sts.clr_last = (clr_r == LAST_IDX);
  assign sts.op_upd   = (op_r == OP_UPDATE);
  assign sts.out_full = out_valid_r & out_stall;

  assign out_valid            = out_valid_r;
  assign out_chosen_component = chosen_r;
  assign out_final_guess      = final_r;

endmodule

// ===== design/four_way_tournament_branch_chooser_core.sv =====
// Path: a lookup beat is captured in the input registers, its entries are read into the
// read registers, then its result is registered onto the out_ ports. No new beat is taken until
// the last is done: an update writes back on the tables' single write port, a lookup its result.
// Reset: rst_n is synchronous and active low; afterward a clearing pass writes the start
// values into all 4096 entries of each table, one entry per cycle, with in_stall held high.
module four_way_tournament_branch_chooser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [31:0] in_branch_address,
  input  logic [3:0]  in_component_guesses,
  input  logic        in_taken_outcome,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_chosen_component,
  output logic        out_final_guess
);
  import ftbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ftbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ftbc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_op                (in_op),
    .in_branch_address    (in_branch_address),
    .in_component_guesses (in_component_guesses),
    .in_taken_outcome     (in_taken_outcome),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_chosen_component (out_chosen_component),
    .out_final_guess      (out_final_guess)
  );

endmodule
